/* sv/bctd_pkg.sv */
// Shared types and constants for the BC1/BC2/BC3 texel block decoder.
// No dependencies; every other file of the block imports this package.
package bctd_pkg;

    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;

    localparam logic [3:0] LAST_TEXEL_IDX = 4'd15;
    localparam logic [7:0] ALPHA_OPAQUE_VAL = 8'd255;

    typedef enum logic [1:0] {
        ALPHA_OPAQUE   = 2'd0,
        ALPHA_EXPLICIT = 2'd1,
        ALPHA_INTERP   = 2'd2
    } alpha_kind_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // One classified block, as handed from the front end to the back end.
    typedef struct packed {
        alpha_kind_t     alpha_kind;
        rgb_t [3:0]      color_pal;
        logic [7:0][7:0] alpha_pal;
        logic [63:0]     alpha_bits;
        logic [31:0]     color_idx;
    } blk_rec_t;

endpackage

/* sv/bctd_front.sv */
// Front end: accepts compressed blocks, holds the format register and builds
// the colour and alpha palettes of each block. Depends on bctd_pkg.
module bctd_front
    import bctd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_alpha_block,
    input  logic [63:0] s_color_block,
    output logic        rec_valid,
    input  logic        rec_ready,
    output blk_rec_t    rec_data
);

    logic [1:0]  fmt_reg;
    logic        stage_valid_reg, stage_valid_next;
    logic [63:0] alpha_word_reg;
    logic [63:0] color_word_reg;
    logic        push;

    // Divisions by constants as reciprocal multiplications; each is exact
    // over the range of operands that the palettes can produce.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [21:0] prod;
        prod = {12'd0, x} * 22'd2731;
        return prod[20:13];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [24:0] prod;
        prod = {14'd0, x} * 25'd3277;
        return prod[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] prod;
        prod = {14'd0, x} * 25'd2341;
        return prod[21:14];
    endfunction

    function automatic rgb_t expand565(input logic [15:0] c);
        rgb_t v;
        v.r = {c[15:11], 3'b000};
        v.g = {c[10:5], 2'b00};
        v.b = {c[4:0], 3'b000};
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg         <= FMT_BC1;
            stage_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fmt_reg <= cfg_wr_data;
            end
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            alpha_word_reg <= s_alpha_block;
            color_word_reg <= s_color_block;
        end
    end

    assign push    = stage_valid_reg && rec_ready;
    assign s_ready = !stage_valid_reg || push;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_valid && s_ready) begin
            stage_valid_next = 1'b1;
        end else if (push) begin
            stage_valid_next = 1'b0;
        end
    end

    assign rec_valid = stage_valid_reg;

    always_comb begin
        logic [15:0] c0, c1;
        logic [7:0]  a0, a1;
        logic        four_color;
        rgb_t        p0, p1;
        logic [10:0] wsum;

        c0 = color_word_reg[15:0];
        c1 = color_word_reg[31:16];
        a0 = alpha_word_reg[7:0];
        a1 = alpha_word_reg[15:8];
        p0 = expand565(c0);
        p1 = expand565(c1);
        four_color = (c0 > c1) || (fmt_reg != FMT_BC1);

        rec_data = '0;
        rec_data.color_pal[0] = p0;
        rec_data.color_pal[1] = p1;
        if (four_color) begin
            rec_data.color_pal[2].r = div3({1'b0, p0.r, 1'b0} + {2'b00, p1.r} + 10'd1);
            rec_data.color_pal[2].g = div3({1'b0, p0.g, 1'b0} + {2'b00, p1.g} + 10'd1);
            rec_data.color_pal[2].b = div3({1'b0, p0.b, 1'b0} + {2'b00, p1.b} + 10'd1);
            rec_data.color_pal[3].r = div3({2'b00, p0.r} + {1'b0, p1.r, 1'b0} + 10'd1);
            rec_data.color_pal[3].g = div3({2'b00, p0.g} + {1'b0, p1.g, 1'b0} + 10'd1);
            rec_data.color_pal[3].b = div3({2'b00, p0.b} + {1'b0, p1.b, 1'b0} + 10'd1);
        end else begin
            // Three-colour mode: rounded mean, and black for the fourth entry.
            rec_data.color_pal[2].r = 8'(({1'b0, p0.r} + {1'b0, p1.r} + 9'd1) >> 1);
            rec_data.color_pal[2].g = 8'(({1'b0, p0.g} + {1'b0, p1.g} + 9'd1) >> 1);
            rec_data.color_pal[2].b = 8'(({1'b0, p0.b} + {1'b0, p1.b} + 9'd1) >> 1);
            rec_data.color_pal[3]   = '0;
        end

        rec_data.alpha_pal[0] = a0;
        rec_data.alpha_pal[1] = a1;
        for (int k = 2; k < 8; k++) begin
            if (a0 > a1) begin
                wsum = 11'(a0) * 11'(8 - k) + 11'(a1) * 11'(k - 1);
                rec_data.alpha_pal[k] = div7(wsum);
            end else if (k == 6) begin
                wsum = '0;
                rec_data.alpha_pal[k] = 8'd0;
            end else if (k == 7) begin
                wsum = '0;
                rec_data.alpha_pal[k] = ALPHA_OPAQUE_VAL;
            end else begin
                wsum = 11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k - 1);
                rec_data.alpha_pal[k] = div5(wsum);
            end
        end

        if (fmt_reg[1]) begin
            rec_data.alpha_kind = ALPHA_INTERP;
        end else if (fmt_reg == FMT_BC2) begin
            rec_data.alpha_kind = ALPHA_EXPLICIT;
        end else begin
            rec_data.alpha_kind = ALPHA_OPAQUE;
        end
        rec_data.alpha_bits = alpha_word_reg;
        rec_data.color_idx  = color_word_reg[63:32];
    end

endmodule

/* sv/bctd_queue.sv */
// Short first-in first-out queue of classified blocks between front and
// back end. Depends on bctd_pkg for the record type.
module bctd_queue
    import bctd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  blk_rec_t wr_data,
    output logic     rd_valid,
    input  logic     rd_pop,
    output blk_rec_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    blk_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("queue occupancy exceeds its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not follow a lone write");

endmodule

/* sv/bctd_back.sv */
// Back end: walks the sixteen texels of a classified block, one per cycle
// unless stalled, into the result output register. Depends on bctd_pkg.
module bctd_back
    import bctd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rec_valid,
    output logic       rec_pop,
    input  blk_rec_t   rec_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_texel_index,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [7:0] m_alpha_out,
    output logic       m_last_texel
);

    blk_rec_t   cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] idx_reg, idx_next;
    rgb_t       rgb_reg, rgb_next;
    logic [7:0] alpha_reg, alpha_next;
    logic       last_reg, last_next;
    logic       advance;
    logic       load;

    assign advance = !out_valid_reg || m_ready;
    // A new block is taken when idle, or as the last texel of the current one moves into the output register.
    assign load    = rec_valid && (!busy_reg || (advance && cnt_reg == LAST_TEXEL_IDX));
    assign rec_pop = load;

    always_comb begin
        logic [1:0] ci;
        logic [3:0] nib;
        logic [2:0] ai;

        ci  = cur_reg.color_idx[{cnt_reg, 1'b0} +: 2];
        nib = cur_reg.alpha_bits[{cnt_reg, 2'b00} +: 4];
        ai  = cur_reg.alpha_bits[6'd16 + 6'(cnt_reg) * 6'd3 +: 3];

        cur_next       = cur_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        rgb_next       = rgb_reg;
        alpha_next     = alpha_reg;
        last_next      = last_reg;

        if (advance) begin
            out_valid_next = busy_reg;
            if (busy_reg) begin
                idx_next  = cnt_reg;
                rgb_next  = cur_reg.color_pal[ci];
                last_next = (cnt_reg == LAST_TEXEL_IDX);
                case (cur_reg.alpha_kind)
                    ALPHA_EXPLICIT: alpha_next = {nib, nib};
                    ALPHA_INTERP:   alpha_next = cur_reg.alpha_pal[ai];
                    default:        alpha_next = ALPHA_OPAQUE_VAL;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TEXEL_IDX) begin
                    busy_next = 1'b0;
                end
            end
        end

        if (load) begin
            cur_next  = rec_data;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        rgb_reg   <= rgb_next;
        alpha_reg <= alpha_next;
        last_reg  <= last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_texel_index = idx_reg;
    assign m_red         = rgb_reg.r;
    assign m_green       = rgb_reg.g;
    assign m_blue        = rgb_reg.b;
    assign m_alpha_out   = alpha_reg;
    assign m_last_texel  = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_texel) |-> (m_texel_index == LAST_TEXEL_IDX))
        else $error("last flag on a texel other than the sixteenth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_texel)
            |=> (m_valid && m_texel_index == $past(m_texel_index) + 4'd1))
        else $error("texels of a block not delivered without a gap and in order");

endmodule

/* sv/bc1_bc3_texel_block_decoder.sv */
// Top level of the BC1/BC2/BC3 texel block decoder: front end, block queue
// and back end. Depends on bctd_pkg, bctd_front, bctd_queue and bctd_back.
//
// Usage:
//   The input channel (s_valid/s_ready) takes one compressed 4x4 block per
//   transaction: s_alpha_block and s_color_block, both 64 bits. The result
//   channel (m_valid/m_ready) gives the sixteen texels of each block in row
//   order, one transaction each, with m_last_texel on the sixteenth.
//   cfg_wr_en/cfg_wr_data write the format register (BC1, BC2, BC3) and take
//   effect for blocks accepted afterwards; write it only while idle.
//   A block passes the input stage, the queue, the back end's block register
//   and the result output register before its first texel appears. The
//   result channel carries one texel a cycle while the receiver is ready;
//   consecutive blocks stream with no gap between their texels.
//   Up to QUEUE_DEPTH + 2 blocks can be held (input stage, queue and the
//   block being emitted), so new blocks are accepted while texels wait.
//   When the receiver stalls, the current texel holds and the input channel
//   stops accepting once that storage is full. Synchronous reset clears
//   all handshake state, empties the queue and sets the format to BC1.
module bc1_bc3_texel_block_decoder
    import bctd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_alpha_block,
    input  logic [63:0] s_color_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_texel_index,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha_out,
    output logic        m_last_texel
);

    logic     front_valid;
    logic     front_ready;
    blk_rec_t front_rec;
    logic     q_valid;
    logic     q_pop;
    blk_rec_t q_rec;

    bctd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_alpha_block (s_alpha_block),
        .s_color_block (s_color_block),
        .rec_valid     (front_valid),
        .rec_ready     (front_ready),
        .rec_data      (front_rec)
    );

    bctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_rec),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_rec)
    );

    bctd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec_valid     (q_valid),
        .rec_pop       (q_pop),
        .rec_data      (q_rec),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_texel_index (m_texel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha_out   (m_alpha_out),
        .m_last_texel  (m_last_texel)
    );

endmodule

/* dv/tb.sv */
// Self-checking testbench for bc1_bc3_texel_block_decoder: random handshakes on both
// channels, with every texel checked against a behavioural prediction of the block.
// Depends on bctd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb;
    import bctd_pkg::*;

    localparam logic [1:0] FMT_BC3   = 2'd2;
    localparam logic [1:0] FMT_SPARE = 2'd3;
    localparam int IDLE_PCT    = 22;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [63:0] alpha_word;
        logic [63:0] color_word;
    } block_t;

    typedef struct {
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_flag;
    } texel_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_wr_data   = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [63:0] s_alpha_block = '0;
    logic [63:0] s_color_block = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [3:0]  m_texel_index;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha_out;
    logic        m_last_texel;

    block_t      blocks_waiting[$];
    texel_t      texels_due[$];
    block_t      shown_block;
    texel_t      want;
    alpha_kind_t cur_kind    = ALPHA_OPAQUE;
    bit          calm        = 1'b0;
    int          errors      = 0;
    int          idle_cycles = 0;

    bc1_bc3_texel_block_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_alpha_block (s_alpha_block),
        .s_color_block (s_color_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_texel_index (m_texel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha_out   (m_alpha_out),
        .m_last_texel  (m_last_texel)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] interp_alpha(logic [7:0] a0, logic [7:0] a1,
                                                logic [2:0] k);
        int ia0;
        int ia1;
        int ik;
        ia0 = a0;
        ia1 = a1;
        ik  = k;
        if (ik == 0) return a0;
        if (ik == 1) return a1;
        if (a0 > a1) return 8'(((8 - ik) * ia0 + (ik - 1) * ia1) / 7);
        // With a0 <= a1 the two top codes are fixed transparent and opaque.
        if (ik == 6) return 8'd0;
        if (ik == 7) return ALPHA_OPAQUE_VAL;
        return 8'(((6 - ik) * ia0 + (ik - 1) * ia1) / 5);
    endfunction

    // Works out the sixteen texels of one block and queues them in row order.
    function automatic void predict_texels(alpha_kind_t kind, logic [63:0] aw,
                                           logic [63:0] cw);
        logic [15:0] c0;
        logic [15:0] c1;
        logic [1:0]  ci;
        int          pal[4][3];
        texel_t      t;
        c0 = cw[15:0];
        c1 = cw[31:16];
        pal[0][0] = int'(c0[15:11]) * 8;
        pal[0][1] = int'(c0[10:5]) * 4;
        pal[0][2] = int'(c0[4:0]) * 8;
        pal[1][0] = int'(c1[15:11]) * 8;
        pal[1][1] = int'(c1[10:5]) * 4;
        pal[1][2] = int'(c1[4:0]) * 8;
        for (int ch = 0; ch < 3; ch++) begin
            // BC2 and BC3 always decode colour in four-colour mode.
            if (c0 > c1 || kind != ALPHA_OPAQUE) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch] + 1) / 3;
                pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch] + 1) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch] + 1) / 2;
                pal[3][ch] = 0;
            end
        end
        for (int i = 0; i < 16; i++) begin
            ci          = cw[32 + 2 * i +: 2];
            t.idx       = 4'(i);
            t.red       = 8'(pal[ci][0]);
            t.green     = 8'(pal[ci][1]);
            t.blue      = 8'(pal[ci][2]);
            t.last_flag = (4'(i) == LAST_TEXEL_IDX);
            case (kind)
                ALPHA_INTERP: begin
                    t.alpha = interp_alpha(aw[7:0], aw[15:8], aw[16 + 3 * i +: 3]);
                end
                ALPHA_EXPLICIT: begin
                    t.alpha = 8'(int'(aw[4 * i +: 4]) * 17);
                end
                default: begin
                    t.alpha = ALPHA_OPAQUE_VAL;
                end
            endcase
            texels_due.push_back(t);
        end
    endfunction

    task automatic check_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: texel %0d %s expected %0h actual %0h",
                     $time, want.idx, what, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic queue_block(logic [63:0] aw, logic [63:0] cw);
        block_t b;
        b.alpha_word = aw;
        b.color_word = cw;
        blocks_waiting.push_back(b);
    endtask

    task automatic queue_random_blocks(int n);
        logic [63:0] aw;
        logic [63:0] cw;
        int          pick;
        for (int i = 0; i < n; i++) begin
            aw   = {$urandom, $urandom};
            cw   = {$urandom, $urandom};
            pick = $urandom_range(0, 7);
            // Steer some blocks onto equal colour endpoints, the three-colour ordering and equal alpha endpoints.
            if (pick == 0) begin
                cw[31:16] = cw[15:0];
            end else if (pick <= 2 && cw[15:0] > cw[31:16]) begin
                cw[31:0] = {cw[15:0], cw[31:16]};
            end else if (pick == 3) begin
                aw[15:8] = aw[7:0];
            end
            queue_block(aw, cw);
        end
    endtask

    task automatic drain();
        while (blocks_waiting.size() != 0 || s_valid || texels_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (5) @(posedge aclk);
    endtask

    task automatic set_format(logic [1:0] f);
        drain();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        if (f[1]) begin
            cur_kind = ALPHA_INTERP;
        end else if (f == FMT_BC2) begin
            cur_kind = ALPHA_EXPLICIT;
        end else begin
            cur_kind = ALPHA_OPAQUE;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender: presents the next block once the previous transaction has gone.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_texels(cur_kind, s_alpha_block, s_color_block);
            end
            if (!s_valid || s_ready) begin
                if (blocks_waiting.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    shown_block   = blocks_waiting.pop_front();
                    s_valid       <= 1'b1;
                    s_alpha_block <= shown_block.alpha_word;
                    s_color_block <= shown_block.color_word;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (texels_due.size() == 0) begin
                $display("%0t: texel %0d arrived with none expected",
                         $time, m_texel_index);
                errors++;
            end else begin
                want = texels_due.pop_front();
                check_field("texel_index", 8'(want.idx), 8'(m_texel_index));
                check_field("red", want.red, m_red);
                check_field("green", want.green, m_green);
                check_field("blue", want.blue, m_blue);
                check_field("alpha_out", want.alpha, m_alpha_out);
                check_field("last_texel", 8'(want.last_flag), 8'(m_last_texel));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("** bc1_bc3_texel_block_decoder: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // BC1 from the reset value: equal, ascending and descending endpoints.
        queue_block(64'h0, 64'h0);
        queue_block('1, '1);
        queue_block(64'h0123456789ABCDEF, {32'hE4E4E4E4, 16'h07E0, 16'hF800});
        queue_block(64'h0, {32'hE4E4E4E4, 16'hF800, 16'h07E0});
        queue_block(64'h0, {32'h1B1B1B1B, 16'h0000, 16'hFFFF});
        queue_block(64'h0, {32'h1B1B1B1B, 16'hFFFF, 16'h0000});
        queue_block(64'h0, {32'hE4E4E4E4, 16'h8410, 16'h8410});

        // BC2 keeps four-colour mode even when c0 is not above c1.
        set_format(FMT_BC2);
        queue_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hF800, 16'h07E0});
        queue_block(64'h0, {32'h1B1B1B1B, 16'h001F, 16'h001F});
        queue_block('1, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});

        // BC3: every alpha code under both endpoint orderings.
        set_format(FMT_BC3);
        queue_block({48'hFAC688FAC688, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        queue_block({48'hFAC688FAC688, 8'hF0, 8'h10}, {32'h1B1B1B1B, 16'hFFFF, 16'h0000});
        queue_block({48'hFAC688FAC688, 8'h80, 8'h80}, {32'hE4E4E4E4, 16'h8410, 16'h8410});
        queue_block({48'hFAC688FAC688, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        queue_block({48'hFAC688FAC688, 8'hFF, 8'h00}, {32'hE4E4E4E4, 16'hF800, 16'h07E0});
        queue_block('1, '1);

        // The unused format code decodes as BC3.
        set_format(FMT_SPARE);
        queue_block({48'hFAC688FAC688, 8'h20, 8'hC0}, {32'hE4E4E4E4, 16'h07E0, 16'hF800});
        queue_block({48'hFAC688FAC688, 8'hC0, 8'h20}, {32'h1B1B1B1B, 16'hF800, 16'h07E0});

        set_format(FMT_BC1);
        queue_random_blocks(30);
        set_format(FMT_BC2);
        queue_random_blocks(30);
        set_format(FMT_BC3);
        calm = 1'b1;
        queue_random_blocks(30);
        drain();
        calm = 1'b0;
        set_format(2'($urandom_range(0, 3)));
        queue_random_blocks(30);
        set_format(FMT_BC1);
        queue_random_blocks(30);

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("** bc1_bc3_texel_block_decoder: PASSED **");
        end else begin
            $display("** bc1_bc3_texel_block_decoder: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/bctd_pkg.sv
sv/bctd_front.sv
sv/bctd_queue.sv
sv/bctd_back.sv
sv/bc1_bc3_texel_block_decoder.sv
dv/tb.sv
